// File: hw/rtl/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Holds the request payload types, result kinds, error codes, the decoder
// state encoding and the small helper functions used by the decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Most results that one input byte can cause (a four-byte UTF-8 sequence).
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [3:0] ERR_NO_OPEN   = 4'd0;
  localparam logic [3:0] ERR_UNTERM    = 4'd1;
  localparam logic [3:0] ERR_CTRL      = 4'd2;
  localparam logic [3:0] ERR_CUT_ESC   = 4'd3;
  localparam logic [3:0] ERR_BAD_HEX   = 4'd4;
  localparam logic [3:0] ERR_NO_BSLASH = 4'd5;
  localparam logic [3:0] ERR_NO_U      = 4'd6;
  localparam logic [3:0] ERR_BAD_LOHEX = 4'd7;
  localparam logic [3:0] ERR_LO_RANGE  = 4'd8;
  localparam logic [3:0] ERR_LONE_LO   = 4'd9;
  localparam logic [3:0] ERR_BAD_ESC   = 4'd10;

  // Characters of interest.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  // Top six bits of a high (D800..DBFF) and a low (DC00..DFFF) surrogate.
  localparam logic [5:0] SURR_HI_TAG = 6'h36;
  localparam logic [5:0] SURR_LO_TAG = 6'h37;
  // Plane offset 0x10000 expressed above the low ten bits of a pair.
  localparam logic [10:0] PLANE_OFS  = 11'h040;

  // Decoder state, one-hot.
  typedef enum logic [6:0] {
    M_IDLE  = 7'b0000001,
    M_BODY  = 7'b0000010,
    M_ESC   = 7'b0000100,
    M_HEX1  = 7'b0001000,
    M_EXPBS = 7'b0010000,
    M_EXPU  = 7'b0100000,
    M_HEX2  = 7'b1000000
  } jsu_mode_e;

  // Input request payload.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } jsu_in_t;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [3:0] error_code;
    logic       last;
  } jsu_out_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [CntW-1:0]             cnt;
    jsu_out_t [MaxRes-1:0]       items;
  } jsu_burst_t;

  // UTF-8 encoding of one code point.
  typedef struct packed {
    logic [CntW-1:0]       cnt;
    logic [MaxRes-1:0][7:0] bytes;
  } jsu_utf8_t;

  // Hex digit value; bit 4 is set when the byte is a valid digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // UTF-8 encoder for code points up to 0x10FFFF.
  function automatic jsu_utf8_t utf8_enc(input logic [20:0] cp);
    jsu_utf8_t u;
    u = '0;
    if (cp <= 21'h00007F) begin
      u.cnt      = CntW'(1);
      u.bytes[0] = cp[7:0];
    end else if (cp <= 21'h0007FF) begin
      u.cnt      = CntW'(2);
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'h00FFFF) begin
      u.cnt      = CntW'(3);
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.cnt      = CntW'(4);
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/jsu_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode: escape decoder and its state registers
// Decodes one accepted byte against the current state and produces the whole
// group of results that the byte causes, together with the next state.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire jsu_in_t    in_data_i,
  output jsu_burst_t      burst_o
);

  jsu_mode_e    mode_q, mode_d;
  logic [1:0]   hc_q, hc_d;
  logic [15:0]  acc_q, acc_d;
  logic [9:0]   hs_q, hs_d;

  logic [7:0]   b;
  logic         eoi;
  logic [4:0]   hv;
  logic [15:0]  acc_nx;
  logic         fail;
  logic [3:0]   fcode;
  logic         emit_byte;
  logic [7:0]   ebyte;
  logic         emit_end;
  logic         emit_utf;
  logic [20:0]  ucp;
  jsu_utf8_t    utf;

  assign b      = in_data_i.in_byte;
  assign eoi    = in_data_i.end_of_input;
  assign hv     = hex_digit(b);
  assign acc_nx = {acc_q[11:0], hv[3:0]};
  assign utf    = utf8_enc(ucp);

  // Next state and the kind of output this byte produces.
  always_comb begin
    mode_d    = mode_q;
    hc_d      = hc_q;
    acc_d     = acc_q;
    hs_d      = hs_q;
    fail      = 1'b0;
    fcode     = ERR_NO_OPEN;
    emit_byte = 1'b0;
    ebyte     = b;
    emit_end  = 1'b0;
    emit_utf  = 1'b0;
    ucp       = {5'd0, acc_nx};
    case (mode_q)
      M_BODY: begin
        if (eoi) begin
          fail  = 1'b1;
          fcode = ERR_UNTERM;
        end else if (b == CH_QUOTE) begin
          mode_d   = M_IDLE;
          emit_end = 1'b1;
        end else if (b < CH_SPACE) begin
          fail  = 1'b1;
          fcode = ERR_CTRL;
        end else if (b == CH_BSLASH) begin
          mode_d = M_ESC;
        end else begin
          emit_byte = 1'b1;
        end
      end
      M_ESC: begin
        if (eoi) begin
          fail  = 1'b1;
          fcode = ERR_CUT_ESC;
        end else begin
          mode_d    = M_BODY;
          emit_byte = 1'b1;
          case (b)
            CH_QUOTE:  ebyte = CH_QUOTE;
            CH_BSLASH: ebyte = CH_BSLASH;
            CH_SLASH:  ebyte = CH_SLASH;
            CH_B:      ebyte = CTL_BS;
            CH_F:      ebyte = CTL_FF;
            CH_N:      ebyte = CTL_LF;
            CH_R:      ebyte = CTL_CR;
            CH_T:      ebyte = CTL_TAB;
            CH_U: begin
              emit_byte = 1'b0;
              mode_d    = M_HEX1;
              hc_d      = 2'd0;
              acc_d     = 16'd0;
            end
            default: begin
              emit_byte = 1'b0;
              fail      = 1'b1;
              fcode     = ERR_BAD_ESC;
            end
          endcase
        end
      end
      M_HEX1, M_HEX2: begin
        if (eoi || !hv[4]) begin
          fail  = 1'b1;
          fcode = (mode_q == M_HEX1) ? ERR_BAD_HEX : ERR_BAD_LOHEX;
        end else begin
          acc_d = acc_nx;
          if (hc_q != 2'd3) begin
            hc_d = hc_q + 2'd1;
          end else begin
            hc_d = 2'd0;
            if (mode_q == M_HEX1) begin
              if (acc_nx[15:10] == SURR_HI_TAG) begin
                hs_d   = acc_nx[9:0];
                mode_d = M_EXPBS;
              end else if (acc_nx[15:10] == SURR_LO_TAG) begin
                fail  = 1'b1;
                fcode = ERR_LONE_LO;
              end else begin
                mode_d   = M_BODY;
                emit_utf = 1'b1;
              end
            end else begin
              if (acc_nx[15:10] != SURR_LO_TAG) begin
                fail  = 1'b1;
                fcode = ERR_LO_RANGE;
              end else begin
                // Pair joins to 0x10000 + (high << 10) + low ten bits.
                mode_d   = M_BODY;
                emit_utf = 1'b1;
                ucp      = {{1'b0, hs_q} + PLANE_OFS, acc_nx[9:0]};
              end
            end
          end
        end
      end
      M_EXPBS: begin
        if (eoi || b != CH_BSLASH) begin
          fail  = 1'b1;
          fcode = ERR_NO_BSLASH;
        end else begin
          mode_d = M_EXPU;
        end
      end
      M_EXPU: begin
        if (eoi || b != CH_U) begin
          fail  = 1'b1;
          fcode = ERR_NO_U;
        end else begin
          mode_d = M_HEX2;
          hc_d   = 2'd0;
          acc_d  = 16'd0;
        end
      end
      default: begin
        if (!eoi && b == CH_QUOTE) begin
          mode_d = M_BODY;
        end else begin
          fail  = 1'b1;
          fcode = ERR_NO_OPEN;
        end
      end
    endcase
    // Any error drops the escape in progress and waits for a new string.
    if (fail) begin
      mode_d = M_IDLE;
      hc_d   = 2'd0;
      acc_d  = 16'd0;
    end
  end

  // Assemble the group of results for this byte.
  always_comb begin
    burst_o = '0;
    if (fail) begin
      burst_o.cnt                 = CntW'(1);
      burst_o.items[0].kind       = KIND_ERROR;
      burst_o.items[0].error_code = fcode;
    end else if (emit_end) begin
      burst_o.cnt           = CntW'(1);
      burst_o.items[0].kind = KIND_END;
    end else if (emit_byte) begin
      burst_o.cnt               = CntW'(1);
      burst_o.items[0].out_byte = ebyte;
    end else if (emit_utf) begin
      burst_o.cnt = utf.cnt;
      for (int i = 0; i < MaxRes; i++) begin
        burst_o.items[i].out_byte = utf.bytes[i];
      end
    end
    for (int i = 0; i < MaxRes; i++) begin
      burst_o.items[i].last = (burst_o.cnt == CntW'(i + 1));
    end
  end

  // State registers advance on every accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hc_q   <= 2'd0;
      acc_q  <= 16'd0;
      hs_q   <= 10'd0;
    end else if (take_i) begin
      mode_q <= mode_d;
      hc_q   <= hc_d;
      acc_q  <= acc_d;
      hs_q   <= hs_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/jsu_burst.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_burst: result group register and output register
// Holds the results of one decoded byte and hands them one at a time to the
// output register, which the receiver may stall.
// ----------------------------------------------------------------------------
module jsu_burst import jsu_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_i,
  input  wire jsu_burst_t  burst_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output jsu_out_t         out_data_o
);

  logic [CntW-1:0]        cnt_q, cnt_d;
  jsu_out_t [MaxRes-1:0]  items_q, items_d;
  logic                   oval_q, oval_d;
  jsu_out_t               odata_q;
  logic                   move;

  // The head result moves on when the output register is empty or drains.
  assign move = (cnt_q != '0) && (!oval_q || !out_stall_i);

  // A new request fits once at most the head result is left and it moves.
  assign in_stall_o = (cnt_q > CntW'(1)) || ((cnt_q == CntW'(1)) && !move);

  always_comb begin
    cnt_d   = cnt_q;
    items_d = items_q;
    if (take_i) begin
      cnt_d   = burst_i.cnt;
      items_d = burst_i.items;
    end else if (move) begin
      cnt_d = cnt_q - CntW'(1);
      for (int i = 0; i < MaxRes - 1; i++) begin
        items_d[i] = items_q[i + 1];
      end
    end
  end

  always_comb begin
    oval_d = oval_q;
    if (move) begin
      oval_d = 1'b1;
    end else if (!out_stall_i) begin
      oval_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      oval_q <= oval_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    items_q <= items_d;
    if (move) begin
      odata_q <= items_q[0];
    end
  end

  assign out_valid_o = oval_q;
  assign out_data_o  = odata_q;

endmodule
`default_nettype wire

// File: hw/rtl/json_string_unescape_utf8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string literal unescaper with UTF-8 output
// Takes the raw bytes of a string literal, starting at the opening quote,
// decodes its escapes and emits the text as UTF-8 bytes, an end marker at
// the closing quote, or an error code.
//
// Usage:
//   The input channel carries one raw byte (or an end-of-input flag) per
//   request; the output channel carries one result per request, with last
//   set on the final result caused by a given input byte. Both channels use
//   valid and stall; a request moves when valid is high and stall is low.
//   A byte is decoded in the cycle it is accepted; its results pass the
//   group register, then the output register. One byte is accepted per cycle
//   while each causes at most one result and the receiver does not stall.
//   A byte that completes a multi-byte UTF-8 sequence causes up to four
//   results, emitted one per cycle from the group register while the receiver
//   does not stall; the input stalls until only the last of them is left
//   and moves on. Bytes that complete nothing, such as the opening quote,
//   cause no result. When the receiver stalls, the output register holds
//   its result and input is taken until the group register holds a result.
//   Reset clears the channels; the decoder then waits for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire jsu_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output jsu_out_t      out_data_o
);

  logic       take;
  jsu_burst_t burst;

  assign take = in_valid_i && !in_stall_o;

  // Decoder with its state registers.
  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .in_data_i (in_data_i),
    .burst_o   (burst)
  );

  // Result group and output register.
  jsu_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .burst_i     (burst),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
